@@ hw/rtl/tbhr_pkg.sv @@
// ----------------------------------------------------------------------------
// Time-of-flight bar hit reconstruction: shared definitions
// Request payload types, register indices, pipeline stage numbers and
// fixed-point constants.
// ----------------------------------------------------------------------------
package tbhr_pkg;

    typedef struct packed {
        logic signed [19:0] time_up;
        logic signed [19:0] time_down;
        logic        [15:0] charge_up;
        logic        [15:0] charge_down;
        logic signed [19:0] flight_time;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pos_from_time;
        logic signed [15:0] pos_from_charge;
        logic               charge_ok;
        logic signed [19:0] tof_at_500;
        logic signed [19:0] tof_at_100;
        logic        [19:0] energy;
        logic               energy_valid;
        logic               gamma_window;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_TIME_DIFF_OFFSET   = 3'd0,
        REG_POSITION_SCALE     = 3'd1,
        REG_CHARGE_SCALE       = 3'd2,
        REG_FLIGHT_TIME_OFFSET = 3'd3,
        REG_BASE_DISTANCE      = 3'd4,
        REG_GATE_LOW           = 3'd5,
        REG_GATE_HIGH          = 3'd6,
        REG_ENERGY_FACTOR      = 3'd7
    } t_reg_idx;

    // Register reset values.
    localparam logic signed [19:0] RST_TIME_DIFF_OFFSET   = 20'sd3804;
    localparam logic        [11:0] RST_POSITION_SCALE     = 12'd960;
    localparam logic        [9:0]  RST_CHARGE_SCALE       = 10'd190;
    localparam logic signed [19:0] RST_FLIGHT_TIME_OFFSET = 20'sd6734;
    localparam logic        [15:0] RST_BASE_DISTANCE      = 16'd8040;
    localparam logic        [18:0] RST_GATE_LOW           = 19'd1280;
    localparam logic        [18:0] RST_GATE_HIGH          = 19'd2816;
    localparam logic        [9:0]  RST_ENERGY_FACTOR      = 10'd72;

    // Fixed-point constants.
    localparam logic signed [31:0] LN2_Q30   = 32'sd744261118;
    localparam logic signed [19:0] GAMMA_LO  = 20'sd10752;
    localparam logic signed [19:0] GAMMA_HI  = 20'sd11264;
    localparam logic        [15:0] GAMMA_X   = 16'd80;
    localparam logic        [28:0] PATH_FAR  = 29'd500;
    localparam logic        [26:0] PATH_NEAR = 27'd100;
    localparam logic signed [15:0] POS_MIN   = 16'sh8000;
    localparam logic signed [15:0] POS_MAX   = 16'sh7FFF;
    localparam logic        [19:0] T_MIN     = 20'h80000;
    localparam logic        [19:0] T_MAX     = 20'h7FFFF;
    localparam logic        [19:0] T_NEG_LIM = 20'd524288;
    localparam logic        [19:0] E_MAX     = 20'hFFFFF;

    // Pipeline stage numbers (register after the named step).
    localparam int S_IN       = 1;   // offsets, log2 start
    localparam int S_MUL      = 2;   // time difference times scale
    localparam int S_TX       = 3;   // time position
    localparam int S_SQ       = 4;   // squares of base and position
    localparam int S_RAD      = 5;   // radicand
    localparam int S_RT_LAST  = 30;  // last square root step
    localparam int S_NUM      = 31;  // dividends and divisor
    localparam int S_OVF      = 32;  // quotient range check
    localparam int S_DV_LAST  = 52;  // last division step
    localparam int S_TOF      = 53;  // signed, saturated flight times
    localparam int S_EN       = 54;  // gate and squares
    localparam int S_EN_N     = 55;  // energy dividend and divisor
    localparam int S_EOVF     = 56;  // energy range check
    localparam int S_EDV_LAST = 76;  // last energy division step
    localparam int S_OUT      = 77;  // output register
    localparam int S_LOG_LAST = 17;  // last log2 squaring step
    localparam int S_DL       = 18;  // log difference
    localparam int S_DLC      = 19;  // times charge scale
    localparam int S_DLL      = 20;  // times ln 2
    localparam int S_QX       = 21;  // charge position

endpackage

@@ hw/rtl/tof_bar_hit_reconstruction.sv @@
// ----------------------------------------------------------------------------
// Time-of-flight bar hit reconstruction
// Turns the end times, end charges and flight time of one bar hit into two
// positions, path-corrected flight times, an energy and a gamma flag.
// ----------------------------------------------------------------------------
// The block takes one hit request per clock while o_ready is high and
// returns one result request per hit, in order. Its depth comes from
// the chain of bit-per-stage units: a 25-stage square root for the path
// length, a 20-stage divider that scales the flight time to 500 cm and
// 100 cm (both in parallel), and a second 20-stage divider for the energy.
// The whole pipeline advances together; when a finished result is not taken
// every stage holds, and o_ready drops in the same cycle. The configuration
// registers sit on an APB-style port and may only be written while no hit
// is in flight.
module tof_bar_hit_reconstruction (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tbhr_pkg::t_in_item   i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tbhr_pkg::t_out_item  o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // ---------------------------------------------------------------- config
    logic signed [19:0] r_cfg_tdo;
    logic        [11:0] r_cfg_ps;
    logic        [9:0]  r_cfg_cs;
    logic signed [19:0] r_cfg_fto;
    logic        [15:0] r_cfg_bd;
    logic        [18:0] r_cfg_gl;
    logic        [18:0] r_cfg_gh;
    logic        [9:0]  r_cfg_ef;
    tbhr_pkg::t_reg_idx w_idx;

    assign w_idx  = tbhr_pkg::t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tdo <= tbhr_pkg::RST_TIME_DIFF_OFFSET;
            r_cfg_ps  <= tbhr_pkg::RST_POSITION_SCALE;
            r_cfg_cs  <= tbhr_pkg::RST_CHARGE_SCALE;
            r_cfg_fto <= tbhr_pkg::RST_FLIGHT_TIME_OFFSET;
            r_cfg_bd  <= tbhr_pkg::RST_BASE_DISTANCE;
            r_cfg_gl  <= tbhr_pkg::RST_GATE_LOW;
            r_cfg_gh  <= tbhr_pkg::RST_GATE_HIGH;
            r_cfg_ef  <= tbhr_pkg::RST_ENERGY_FACTOR;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                tbhr_pkg::REG_TIME_DIFF_OFFSET:   r_cfg_tdo <= pwdata[19:0];
                tbhr_pkg::REG_POSITION_SCALE:     r_cfg_ps  <= pwdata[11:0];
                tbhr_pkg::REG_CHARGE_SCALE:       r_cfg_cs  <= pwdata[9:0];
                tbhr_pkg::REG_FLIGHT_TIME_OFFSET: r_cfg_fto <= pwdata[19:0];
                tbhr_pkg::REG_BASE_DISTANCE:      r_cfg_bd  <= pwdata[15:0];
                tbhr_pkg::REG_GATE_LOW:           r_cfg_gl  <= pwdata[18:0];
                tbhr_pkg::REG_GATE_HIGH:          r_cfg_gh  <= pwdata[18:0];
                tbhr_pkg::REG_ENERGY_FACTOR:      r_cfg_ef  <= pwdata[9:0];
            endcase
        end
    end

    // Reads return the raw register bits, zero-extended.
    always_comb begin
        unique case (w_idx)
            tbhr_pkg::REG_TIME_DIFF_OFFSET:   prdata = {12'b0, r_cfg_tdo};
            tbhr_pkg::REG_POSITION_SCALE:     prdata = {20'b0, r_cfg_ps};
            tbhr_pkg::REG_CHARGE_SCALE:       prdata = {22'b0, r_cfg_cs};
            tbhr_pkg::REG_FLIGHT_TIME_OFFSET: prdata = {12'b0, r_cfg_fto};
            tbhr_pkg::REG_BASE_DISTANCE:      prdata = {16'b0, r_cfg_bd};
            tbhr_pkg::REG_GATE_LOW:           prdata = {13'b0, r_cfg_gl};
            tbhr_pkg::REG_GATE_HIGH:          prdata = {13'b0, r_cfg_gh};
            tbhr_pkg::REG_ENERGY_FACTOR:      prdata = {22'b0, r_cfg_ef};
        endcase
    end

    // ----------------------------------------------------------- helpers
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v < 32'(tbhr_pkg::POS_MIN)) begin
            return tbhr_pkg::POS_MIN;
        end else if (v > 32'(tbhr_pkg::POS_MAX)) begin
            return tbhr_pkg::POS_MAX;
        end
        return v[15:0];
    endfunction

    function automatic logic [3:0] msb_index(input logic [15:0] q);
        logic [3:0] k;
        k = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (q[i]) begin
                k = 4'(i);
            end
        end
        return k;
    endfunction

    // Magnitude quotient to signed, saturated 20-bit flight time.
    function automatic logic [19:0] tof_sat(input logic neg, input logic ovf,
                                            input logic [19:0] q);
        if (ovf) begin
            return neg ? tbhr_pkg::T_MIN : tbhr_pkg::T_MAX;
        end else if (neg) begin
            return (q > tbhr_pkg::T_NEG_LIM) ? tbhr_pkg::T_MIN : 20'(-q);
        end
        return (q > tbhr_pkg::T_MAX) ? tbhr_pkg::T_MAX : q;
    endfunction

    // ------------------------------------------------------- flow control
    // Valid bits travel with the data; all stages shift together.
    logic r_v [tbhr_pkg::S_IN:tbhr_pkg::S_OUT];
    logic w_adv;

    assign w_adv   = !r_v[tbhr_pkg::S_OUT] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v[tbhr_pkg::S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = tbhr_pkg::S_IN; s <= tbhr_pkg::S_OUT; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[tbhr_pkg::S_IN] <= i_valid;
            for (int s = tbhr_pkg::S_IN + 1; s <= tbhr_pkg::S_OUT; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // ------------------------------------------------------ datapath regs
    logic signed [21:0] r1_diff;
    logic signed [20:0] r1_num;
    logic               r_gwt  [tbhr_pkg::S_IN:tbhr_pkg::S_TX];
    logic               r_qok  [tbhr_pkg::S_IN:tbhr_pkg::S_OUT];
    logic signed [34:0] r_prod;
    logic        [20:0] r_anum;
    logic               r_neg  [tbhr_pkg::S_MUL:tbhr_pkg::S_DV_LAST];
    logic signed [15:0] r_tx   [tbhr_pkg::S_TX:tbhr_pkg::S_OUT];
    logic        [15:0] r_ax;
    logic        [28:0] r_m500 [tbhr_pkg::S_TX:tbhr_pkg::S_RT_LAST];
    logic        [26:0] r_m100 [tbhr_pkg::S_TX:tbhr_pkg::S_RT_LAST];
    logic               r_gw   [tbhr_pkg::S_SQ:tbhr_pkg::S_OUT];
    logic        [31:0] r_bsq;
    logic        [31:0] r_asq;

    // Square root: remainder and partial root, one result bit per stage.
    logic [48:0] r_rrem [tbhr_pkg::S_RAD:tbhr_pkg::S_RT_LAST];
    logic [24:0] r_root [tbhr_pkg::S_RAD:tbhr_pkg::S_RT_LAST];
    logic [48:0] n_rrem [tbhr_pkg::S_RAD+1:tbhr_pkg::S_RT_LAST];
    logic [24:0] n_root [tbhr_pkg::S_RAD+1:tbhr_pkg::S_RT_LAST];

    // Flight time dividers, both scaled paths share the divisor.
    logic [25:0] r_d2     [tbhr_pkg::S_NUM:tbhr_pkg::S_DV_LAST];
    logic [42:0] r_rem500 [tbhr_pkg::S_NUM:tbhr_pkg::S_DV_LAST];
    logic [42:0] r_rem100 [tbhr_pkg::S_NUM:tbhr_pkg::S_DV_LAST];
    logic [19:0] r_quo500 [tbhr_pkg::S_OVF:tbhr_pkg::S_DV_LAST];
    logic [19:0] r_quo100 [tbhr_pkg::S_OVF:tbhr_pkg::S_DV_LAST];
    logic        r_ovf500 [tbhr_pkg::S_OVF:tbhr_pkg::S_DV_LAST];
    logic        r_ovf100 [tbhr_pkg::S_OVF:tbhr_pkg::S_DV_LAST];
    logic [42:0] n_rem500 [tbhr_pkg::S_OVF+1:tbhr_pkg::S_DV_LAST];
    logic [42:0] n_rem100 [tbhr_pkg::S_OVF+1:tbhr_pkg::S_DV_LAST];
    logic [19:0] n_quo500 [tbhr_pkg::S_OVF+1:tbhr_pkg::S_DV_LAST];
    logic [19:0] n_quo100 [tbhr_pkg::S_OVF+1:tbhr_pkg::S_DV_LAST];
    logic [19:0] r_t500   [tbhr_pkg::S_TOF:tbhr_pkg::S_OUT];
    logic [19:0] r_t100   [tbhr_pkg::S_TOF:tbhr_pkg::S_OUT];

    // Log2 by repeated squaring of the Q1.30 mantissa.
    logic [3:0]  r_lk_u [tbhr_pkg::S_IN:tbhr_pkg::S_LOG_LAST];
    logic [3:0]  r_lk_d [tbhr_pkg::S_IN:tbhr_pkg::S_LOG_LAST];
    logic [15:0] r_lf_u [tbhr_pkg::S_IN:tbhr_pkg::S_LOG_LAST];
    logic [15:0] r_lf_d [tbhr_pkg::S_IN:tbhr_pkg::S_LOG_LAST];
    logic [30:0] r_ly_u [tbhr_pkg::S_IN:tbhr_pkg::S_LOG_LAST];
    logic [30:0] r_ly_d [tbhr_pkg::S_IN:tbhr_pkg::S_LOG_LAST];
    logic [15:0] n_lf_u [tbhr_pkg::S_IN+1:tbhr_pkg::S_LOG_LAST];
    logic [15:0] n_lf_d [tbhr_pkg::S_IN+1:tbhr_pkg::S_LOG_LAST];
    logic [30:0] n_ly_u [tbhr_pkg::S_IN+1:tbhr_pkg::S_LOG_LAST];
    logic [30:0] n_ly_d [tbhr_pkg::S_IN+1:tbhr_pkg::S_LOG_LAST];
    logic signed [20:0] r_dl;
    logic signed [31:0] r_p1;
    logic signed [62:0] r_p2;
    logic signed [15:0] r_qx [tbhr_pkg::S_QX:tbhr_pkg::S_OUT];

    // Energy.
    logic        r_ev   [tbhr_pkg::S_EN:tbhr_pkg::S_OUT];
    logic [37:0] r_den;
    logic [19:0] r_ef2;
    logic [41:0] r_erem [tbhr_pkg::S_EN_N:tbhr_pkg::S_EDV_LAST];
    logic [38:0] r_ede  [tbhr_pkg::S_EN_N:tbhr_pkg::S_EDV_LAST];
    logic        r_eovf [tbhr_pkg::S_EOVF:tbhr_pkg::S_EDV_LAST];
    logic [19:0] r_equo [tbhr_pkg::S_EOVF:tbhr_pkg::S_EDV_LAST];
    logic [41:0] n_erem [tbhr_pkg::S_EOVF+1:tbhr_pkg::S_EDV_LAST];
    logic [19:0] n_equo [tbhr_pkg::S_EOVF+1:tbhr_pkg::S_EDV_LAST];
    logic [19:0] r_e;

    // ------------------------------------------------- combinational steps
    logic signed [35:0] w_txsum;
    logic signed [35:0] w_txsh;
    logic signed [15:0] w_tx;
    logic signed [63:0] w_qxsum;
    logic signed [63:0] w_qxsh;
    logic        [24:0] w_d;
    logic        [3:0]  w_ku;
    logic        [3:0]  w_kd;

    assign w_txsum = $signed({r_prod[34], r_prod}) + 36'sd2048;
    assign w_txsh  = w_txsum >>> 12;
    assign w_tx    = sat16(w_txsh[31:0]);
    assign w_qxsum = $signed({r_p2[62], r_p2}) + 64'sd2199023255552;
    assign w_qxsh  = w_qxsum >>> 42;
    assign w_d     = (r_root[tbhr_pkg::S_RT_LAST] == 25'd0) ? 25'd1
                                                            : r_root[tbhr_pkg::S_RT_LAST];
    assign w_ku    = msb_index(i_in.charge_up);
    assign w_kd    = msb_index(i_in.charge_down);

    // Square root stages: bit i of the root is tried by comparing the
    // remainder with 2*root*2^i + 2^(2i).
    always_comb begin
        logic [50:0] v_trial;
        for (int s = tbhr_pkg::S_RAD + 1; s <= tbhr_pkg::S_RT_LAST; s++) begin
            v_trial = (51'(r_root[s-1]) << (tbhr_pkg::S_RT_LAST - s + 1))
                    + (51'(1) << (2 * (tbhr_pkg::S_RT_LAST - s)));
            if (51'(r_rrem[s-1]) >= v_trial) begin
                n_rrem[s] = 49'(51'(r_rrem[s-1]) - v_trial);
                n_root[s] = r_root[s-1] | (25'(1) << (tbhr_pkg::S_RT_LAST - s));
            end else begin
                n_rrem[s] = r_rrem[s-1];
                n_root[s] = r_root[s-1];
            end
        end
    end

    // Restoring division of the flight time dividends, quotient bit 19 first.
    always_comb begin
        logic [45:0] v_dsh;
        for (int s = tbhr_pkg::S_OVF + 1; s <= tbhr_pkg::S_DV_LAST; s++) begin
            v_dsh = 46'(r_d2[s-1]) << (tbhr_pkg::S_DV_LAST - s);
            if (46'(r_rem500[s-1]) >= v_dsh) begin
                n_rem500[s] = 43'(46'(r_rem500[s-1]) - v_dsh);
                n_quo500[s] = r_quo500[s-1] | (20'(1) << (tbhr_pkg::S_DV_LAST - s));
            end else begin
                n_rem500[s] = r_rem500[s-1];
                n_quo500[s] = r_quo500[s-1];
            end
            if (46'(r_rem100[s-1]) >= v_dsh) begin
                n_rem100[s] = 43'(46'(r_rem100[s-1]) - v_dsh);
                n_quo100[s] = r_quo100[s-1] | (20'(1) << (tbhr_pkg::S_DV_LAST - s));
            end else begin
                n_rem100[s] = r_rem100[s-1];
                n_quo100[s] = r_quo100[s-1];
            end
        end
    end

    // Energy division, same scheme.
    always_comb begin
        logic [58:0] v_esh;
        for (int s = tbhr_pkg::S_EOVF + 1; s <= tbhr_pkg::S_EDV_LAST; s++) begin
            v_esh = 59'(r_ede[s-1]) << (tbhr_pkg::S_EDV_LAST - s);
            if (59'(r_erem[s-1]) >= v_esh) begin
                n_erem[s] = 42'(59'(r_erem[s-1]) - v_esh);
                n_equo[s] = r_equo[s-1] | (20'(1) << (tbhr_pkg::S_EDV_LAST - s));
            end else begin
                n_erem[s] = r_erem[s-1];
                n_equo[s] = r_equo[s-1];
            end
        end
    end

    // Log2 fraction: square the mantissa; when it reaches 2 the next
    // fraction bit is one and the mantissa is halved.
    always_comb begin
        logic [61:0] v_squ;
        logic [61:0] v_sqd;
        for (int s = tbhr_pkg::S_IN + 1; s <= tbhr_pkg::S_LOG_LAST; s++) begin
            v_squ = 62'(r_ly_u[s-1]) * 62'(r_ly_u[s-1]);
            v_sqd = 62'(r_ly_d[s-1]) * 62'(r_ly_d[s-1]);
            n_ly_u[s] = v_squ[61] ? v_squ[61:31] : v_squ[60:30];
            n_ly_d[s] = v_sqd[61] ? v_sqd[61:31] : v_sqd[60:30];
            n_lf_u[s] = {r_lf_u[s-1][14:0], v_squ[61]};
            n_lf_d[s] = {r_lf_d[s-1][14:0], v_sqd[61]};
        end
    end

    // ---------------------------------------------------- pipeline registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // Entry stage.
            r1_diff <= 22'(i_in.time_down) - 22'(i_in.time_up) - 22'(r_cfg_tdo);
            r1_num  <= 21'(i_in.flight_time) - 21'(r_cfg_fto);
            r_gwt[tbhr_pkg::S_IN] <= (i_in.flight_time > tbhr_pkg::GAMMA_LO)
                                  && (i_in.flight_time < tbhr_pkg::GAMMA_HI);
            r_qok[tbhr_pkg::S_IN] <= (i_in.charge_up != 16'd0)
                                  && (i_in.charge_down != 16'd0);
            r_lk_u[tbhr_pkg::S_IN] <= w_ku;
            r_lk_d[tbhr_pkg::S_IN] <= w_kd;
            r_lf_u[tbhr_pkg::S_IN] <= 16'd0;
            r_lf_d[tbhr_pkg::S_IN] <= 16'd0;
            r_ly_u[tbhr_pkg::S_IN] <= 31'({i_in.charge_up, 30'b0} >> w_ku);
            r_ly_d[tbhr_pkg::S_IN] <= 31'({i_in.charge_down, 30'b0} >> w_kd);

            // Time position.
            r_prod <= r1_diff * $signed({1'b0, r_cfg_ps});
            r_anum <= r1_num[20] ? 21'(-r1_num) : 21'(r1_num);
            r_neg[tbhr_pkg::S_MUL] <= r1_num[20];
            r_tx[tbhr_pkg::S_TX]   <= w_tx;
            r_ax   <= w_tx[15] ? 16'(-w_tx) : 16'(w_tx);
            r_m500[tbhr_pkg::S_TX] <= 29'(r_anum) * tbhr_pkg::PATH_FAR;
            r_m100[tbhr_pkg::S_TX] <= 27'(r_anum) * tbhr_pkg::PATH_NEAR;
            r_gw[tbhr_pkg::S_SQ]   <= r_gwt[tbhr_pkg::S_TX] && (r_ax < tbhr_pkg::GAMMA_X);

            // Path length.
            r_bsq <= 32'(r_cfg_bd) * 32'(r_cfg_bd);
            r_asq <= 32'(r_ax) * 32'(r_ax);
            r_rrem[tbhr_pkg::S_RAD] <= {33'(r_bsq) + 33'(r_asq), 16'b0};
            r_root[tbhr_pkg::S_RAD] <= 25'd0;
            for (int s = tbhr_pkg::S_RAD + 1; s <= tbhr_pkg::S_RT_LAST; s++) begin
                r_rrem[s] <= n_rrem[s];
                r_root[s] <= n_root[s];
            end

            // Flight time scaling: q = (2m + d) / (2d) rounds half away
            // from zero once the sign is put back.
            r_d2[tbhr_pkg::S_NUM]     <= {w_d, 1'b0};
            r_rem500[tbhr_pkg::S_NUM] <= (43'(r_m500[tbhr_pkg::S_RT_LAST]) << 13)
                                       + 43'(w_d);
            r_rem100[tbhr_pkg::S_NUM] <= (43'(r_m100[tbhr_pkg::S_RT_LAST]) << 13)
                                       + 43'(w_d);
            r_d2[tbhr_pkg::S_OVF]     <= r_d2[tbhr_pkg::S_NUM];
            r_rem500[tbhr_pkg::S_OVF] <= r_rem500[tbhr_pkg::S_NUM];
            r_rem100[tbhr_pkg::S_OVF] <= r_rem100[tbhr_pkg::S_NUM];
            r_quo500[tbhr_pkg::S_OVF] <= 20'd0;
            r_quo100[tbhr_pkg::S_OVF] <= 20'd0;
            r_ovf500[tbhr_pkg::S_OVF] <= 46'(r_rem500[tbhr_pkg::S_NUM])
                                      >= (46'(r_d2[tbhr_pkg::S_NUM]) << 20);
            r_ovf100[tbhr_pkg::S_OVF] <= 46'(r_rem100[tbhr_pkg::S_NUM])
                                      >= (46'(r_d2[tbhr_pkg::S_NUM]) << 20);
            for (int s = tbhr_pkg::S_OVF + 1; s <= tbhr_pkg::S_DV_LAST; s++) begin
                r_d2[s]     <= r_d2[s-1];
                r_rem500[s] <= n_rem500[s];
                r_rem100[s] <= n_rem100[s];
                r_quo500[s] <= n_quo500[s];
                r_quo100[s] <= n_quo100[s];
                r_ovf500[s] <= r_ovf500[s-1];
                r_ovf100[s] <= r_ovf100[s-1];
            end
            r_t500[tbhr_pkg::S_TOF] <= tof_sat(r_neg[tbhr_pkg::S_DV_LAST],
                                               r_ovf500[tbhr_pkg::S_DV_LAST],
                                               r_quo500[tbhr_pkg::S_DV_LAST]);
            r_t100[tbhr_pkg::S_TOF] <= tof_sat(r_neg[tbhr_pkg::S_DV_LAST],
                                               r_ovf100[tbhr_pkg::S_DV_LAST],
                                               r_quo100[tbhr_pkg::S_DV_LAST]);

            // Energy: only meaningful for a positive time inside the gate,
            // so the low 19 bits carry the whole value there.
            r_ev[tbhr_pkg::S_EN] <=
                ($signed(r_t100[tbhr_pkg::S_TOF]) > $signed({1'b0, r_cfg_gl}))
             && ($signed(r_t100[tbhr_pkg::S_TOF]) < $signed({1'b0, r_cfg_gh}));
            r_den <= 38'(r_t100[tbhr_pkg::S_TOF][18:0])
                   * 38'(r_t100[tbhr_pkg::S_TOF][18:0]);
            r_ef2 <= 20'(r_cfg_ef) * 20'(r_cfg_ef);
            r_erem[tbhr_pkg::S_EN_N] <= (42'(r_ef2) << 21) + 42'(r_den);
            r_ede[tbhr_pkg::S_EN_N]  <= {r_den, 1'b0};
            r_erem[tbhr_pkg::S_EOVF] <= r_erem[tbhr_pkg::S_EN_N];
            r_ede[tbhr_pkg::S_EOVF]  <= r_ede[tbhr_pkg::S_EN_N];
            r_equo[tbhr_pkg::S_EOVF] <= 20'd0;
            r_eovf[tbhr_pkg::S_EOVF] <= 59'(r_erem[tbhr_pkg::S_EN_N])
                                     >= (59'(r_ede[tbhr_pkg::S_EN_N]) << 20);
            for (int s = tbhr_pkg::S_EOVF + 1; s <= tbhr_pkg::S_EDV_LAST; s++) begin
                r_erem[s] <= n_erem[s];
                r_ede[s]  <= r_ede[s-1];
                r_equo[s] <= n_equo[s];
                r_eovf[s] <= r_eovf[s-1];
            end
            if (!r_ev[tbhr_pkg::S_EDV_LAST]) begin
                r_e <= 20'd0;
            end else if (r_eovf[tbhr_pkg::S_EDV_LAST]) begin
                r_e <= tbhr_pkg::E_MAX;
            end else begin
                r_e <= r_equo[tbhr_pkg::S_EDV_LAST];
            end

            // Charge position.
            for (int s = tbhr_pkg::S_IN + 1; s <= tbhr_pkg::S_LOG_LAST; s++) begin
                r_lk_u[s] <= r_lk_u[s-1];
                r_lk_d[s] <= r_lk_d[s-1];
                r_lf_u[s] <= n_lf_u[s];
                r_lf_d[s] <= n_lf_d[s];
                r_ly_u[s] <= n_ly_u[s];
                r_ly_d[s] <= n_ly_d[s];
            end
            r_dl <= $signed({1'b0, r_lk_u[tbhr_pkg::S_LOG_LAST], r_lf_u[tbhr_pkg::S_LOG_LAST]})
                  - $signed({1'b0, r_lk_d[tbhr_pkg::S_LOG_LAST], r_lf_d[tbhr_pkg::S_LOG_LAST]});
            r_p1 <= r_dl * $signed({1'b0, r_cfg_cs});
            r_p2 <= r_p1 * tbhr_pkg::LN2_Q30;
            r_qx[tbhr_pkg::S_QX] <= r_qok[tbhr_pkg::S_DLL] ? sat16(w_qxsh[31:0]) : 16'sd0;

            // Delay lines that line the fields up at the output.
            for (int s = tbhr_pkg::S_IN + 1; s <= tbhr_pkg::S_TX; s++) begin
                r_gwt[s] <= r_gwt[s-1];
            end
            for (int s = tbhr_pkg::S_IN + 1; s <= tbhr_pkg::S_OUT; s++) begin
                r_qok[s] <= r_qok[s-1];
            end
            for (int s = tbhr_pkg::S_MUL + 1; s <= tbhr_pkg::S_DV_LAST; s++) begin
                r_neg[s] <= r_neg[s-1];
            end
            for (int s = tbhr_pkg::S_TX + 1; s <= tbhr_pkg::S_RT_LAST; s++) begin
                r_m500[s] <= r_m500[s-1];
                r_m100[s] <= r_m100[s-1];
            end
            for (int s = tbhr_pkg::S_TX + 1; s <= tbhr_pkg::S_OUT; s++) begin
                r_tx[s] <= r_tx[s-1];
            end
            for (int s = tbhr_pkg::S_SQ + 1; s <= tbhr_pkg::S_OUT; s++) begin
                r_gw[s] <= r_gw[s-1];
            end
            for (int s = tbhr_pkg::S_TOF + 1; s <= tbhr_pkg::S_OUT; s++) begin
                r_t500[s] <= r_t500[s-1];
                r_t100[s] <= r_t100[s-1];
            end
            for (int s = tbhr_pkg::S_EN + 1; s <= tbhr_pkg::S_OUT; s++) begin
                r_ev[s] <= r_ev[s-1];
            end
            for (int s = tbhr_pkg::S_QX + 1; s <= tbhr_pkg::S_OUT; s++) begin
                r_qx[s] <= r_qx[s-1];
            end
        end
    end

    // ------------------------------------------------------------- output
    always_comb begin
        o_out.pos_from_time   = r_tx[tbhr_pkg::S_OUT];
        o_out.pos_from_charge = r_qx[tbhr_pkg::S_OUT];
        o_out.charge_ok       = r_qok[tbhr_pkg::S_OUT];
        o_out.tof_at_500      = r_t500[tbhr_pkg::S_OUT];
        o_out.tof_at_100      = r_t100[tbhr_pkg::S_OUT];
        o_out.energy          = r_e;
        o_out.energy_valid    = r_ev[tbhr_pkg::S_OUT];
        o_out.gamma_window    = r_gw[tbhr_pkg::S_OUT];
    end

endmodule

@@ hw/rtl/tbhr_checker.sv @@
// ----------------------------------------------------------------------------
// Time-of-flight bar hit reconstruction: port checker
// Watches the result side of the top level and checks field consistency.
// ----------------------------------------------------------------------------
module tbhr_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input tbhr_pkg::t_out_item  o_out
);

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Nothing comes out in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.charge_ok |-> o_out.pos_from_charge == 16'sd0)
        else $error("charge position not cleared for a zero charge");

    a_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.energy_valid |-> o_out.energy == 20'd0)
        else $error("energy not cleared outside the gate");

    a_gamma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.gamma_window |->
            o_out.pos_from_time > -16'sd80 && o_out.pos_from_time < 16'sd80)
        else $error("gamma flag with a position outside the window");

endmodule

bind tof_bar_hit_reconstruction tbhr_checker u_tbhr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_out   (o_out)
);
